// ----- sv/trd_pkg.sv -----
package trd_pkg;

  localparam int unsigned CoordW = 12;

  localparam logic [CoordW-1:0] PANEL_WIDTH  = 12'd240;
  localparam logic [CoordW-1:0] PANEL_HEIGHT = 12'd280;

  // raw event codes carried in bits 7..6 of report byte 2
  localparam logic [1:0] RAW_LIFT     = 2'd1;
  localparam logic [1:0] RAW_RESERVED = 2'd3;

  typedef enum logic [1:0] {
    EV_NONE = 2'd0,
    EV_DOWN = 2'd1,
    EV_MOVE = 2'd2,
    EV_UP   = 2'd3
  } event_e;

  typedef enum logic [1:0] {
    ROT_0   = 2'd0,
    ROT_90  = 2'd1,
    ROT_180 = 2'd2,
    ROT_270 = 2'd3
  } rotation_e;

  typedef struct packed {
    logic [7:0] gesture_byte;
    logic [7:0] finger_byte;
    logic [7:0] x_high_byte;
    logic [7:0] x_low_byte;
    logic [7:0] y_high_byte;
    logic [7:0] y_low_byte;
    logic       prior_seen;
    logic       prior_pressed;
  } trd_in_t;

  typedef struct packed {
    logic              accepted;
    event_e            event_kind;
    logic [CoordW-1:0] x_position;
    logic [CoordW-1:0] y_position;
    logic              pressed;
    logic              position_valid;
    logic [7:0]        gesture;
    logic [7:0]        finger_count;
    logic [1:0]        event_code;
  } trd_out_t;

  // classification result handed to the rotation stage
  typedef struct packed {
    logic              ok;
    logic              pos;
    event_e            ev;
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
  } trd_cls_t;

endpackage

// ----- sv/touch_report_decoder.sv -----
// touch report decoder
// in channel: one six-byte touch report plus the previous valid/pressed
// flags per beat (in_valid_i/in_ready_o, payload in_data_i).
// out channel: one decoded result per report (out_valid_o/out_ready_i,
// payload out_data_o), in order, exactly one result per input beat.
// cfg channel: cfg_valid_i/cfg_ready_o with cfg_data_i writes the 2-bit
// rotation; write it only while no report is in flight.
// a report passes two register stages (input register, result register)
// on its way to out_valid_o.
// throughput: one report per cycle unless the receiver stalls; decode is a
// single pass of compare and subtract logic between the two registers.
// reset: both stages empty, rotation back to 0, cfg_ready_o always high.
// when the receiver stalls, the result register holds its beat and the
// input register still takes one more report; after that in_ready_o drops
// until the result is taken.
module touch_report_decoder (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  trd_pkg::trd_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output trd_pkg::trd_out_t out_data_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [1:0]        cfg_data_i
);
  import trd_pkg::*;

  rotation_e         rotation_q;
  logic              s1_valid_q;
  trd_in_t           s1_data_q;
  logic              out_valid_q;
  trd_out_t          out_data_q;
  trd_out_t          out_data_d;
  logic              out_take;
  trd_cls_t          cls;
  logic [CoordW-1:0] x_rot;
  logic [CoordW-1:0] y_rot;

  assign cfg_ready_o = 1'b1;
  assign out_take    = !out_valid_q || out_ready_i;
  assign in_ready_o  = !s1_valid_q || out_take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rotation_q <= ROT_0;
    end else if (cfg_valid_i) begin
      rotation_q <= rotation_e'(cfg_data_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_data_q <= in_data_i;
    end
  end

  trd_classify u_classify (
    .rpt_i (s1_data_q),
    .cls_o (cls)
  );

  trd_rotate u_rotate (
    .cls_i      (cls),
    .rotation_i (rotation_q),
    .x_o        (x_rot),
    .y_o        (y_rot)
  );

  always_comb begin
    out_data_d.accepted       = cls.ok;
    out_data_d.event_kind     = cls.ev;
    out_data_d.x_position     = x_rot;
    out_data_d.y_position     = y_rot;
    out_data_d.pressed        = cls.pos;
    out_data_d.position_valid = cls.pos;
    out_data_d.gesture        = s1_data_q.gesture_byte;
    out_data_d.finger_count   = s1_data_q.finger_byte;
    out_data_d.event_code     = s1_data_q.x_high_byte[7:6];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_take) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q && out_take) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef SYNTHESIS
  // an accepted input beat always lands in the input register
  a_in_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> s1_valid_q)
    else $error("accepted beat not held in input register");

  // a waiting input beat moves to the result register when it frees up
  a_s1_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && out_take |=> out_valid_o)
    else $error("decoded beat lost between stages");

  // rejected reports carry no event and no position
  a_reject_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.accepted |->
      out_data_o.event_kind == EV_NONE && !out_data_o.position_valid)
    else $error("rejected report with event or position");

  // without a position the coordinates are zero
  a_no_pos_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.position_valid |->
      out_data_o.x_position == '0 && out_data_o.y_position == '0)
    else $error("coordinates set without a position");

  // a positioned result is always down or move
  a_pos_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.position_valid |->
      out_data_o.event_kind == EV_DOWN || out_data_o.event_kind == EV_MOVE)
    else $error("positioned result with wrong event");
`endif

endmodule

// ----- sv/trd_classify.sv -----
module trd_classify (
  input  trd_pkg::trd_in_t  rpt_i,
  output trd_pkg::trd_cls_t cls_o
);
  import trd_pkg::*;

  logic [1:0]        raw;
  logic [CoordW-1:0] x_raw;
  logic [CoordW-1:0] y_raw;
  logic              prev_down;

  assign raw       = rpt_i.x_high_byte[7:6];
  assign x_raw     = {rpt_i.x_high_byte[3:0], rpt_i.x_low_byte};
  assign y_raw     = {rpt_i.y_high_byte[3:0], rpt_i.y_low_byte};
  assign prev_down = rpt_i.prior_seen & rpt_i.prior_pressed;

  always_comb begin
    cls_o.ok  = 1'b1;
    cls_o.pos = 1'b0;
    cls_o.x   = '0;
    cls_o.y   = '0;
    if (rpt_i.finger_byte > 8'd1) begin
      cls_o.ok = 1'b0;
    end else if (raw == RAW_LIFT || rpt_i.finger_byte == 8'd0) begin
      // lift or no finger: accepted without a position
      cls_o.pos = 1'b0;
    end else if (raw == RAW_RESERVED) begin
      cls_o.ok = 1'b0;
    end else if (x_raw > PANEL_WIDTH || y_raw > PANEL_HEIGHT) begin
      cls_o.ok = 1'b0;
    end else begin
      cls_o.pos = 1'b1;
      // coordinate on the far edge clamps to the last pixel
      cls_o.x = (x_raw == PANEL_WIDTH) ? PANEL_WIDTH - 12'd1 : x_raw;
      cls_o.y = (y_raw == PANEL_HEIGHT) ? PANEL_HEIGHT - 12'd1 : y_raw;
    end

    if (!cls_o.ok) begin
      cls_o.ev = EV_NONE;
    end else if (cls_o.pos) begin
      cls_o.ev = prev_down ? EV_MOVE : EV_DOWN;
    end else begin
      cls_o.ev = prev_down ? EV_UP : EV_NONE;
    end
  end

endmodule

// ----- sv/trd_rotate.sv -----
module trd_rotate (
  input  trd_pkg::trd_cls_t      cls_i,
  input  trd_pkg::rotation_e     rotation_i,
  output logic [trd_pkg::CoordW-1:0] x_o,
  output logic [trd_pkg::CoordW-1:0] y_o
);
  import trd_pkg::*;

  logic [CoordW-1:0] x_mirror;
  logic [CoordW-1:0] y_mirror;

  // 12-bit modular, matches wraparound for clamped coordinates
  assign x_mirror = PANEL_WIDTH - 12'd1 - cls_i.x;
  assign y_mirror = PANEL_HEIGHT - 12'd1 - cls_i.y;

  always_comb begin
    x_o = cls_i.x;
    y_o = cls_i.y;
    if (cls_i.pos) begin
      unique case (rotation_i)
        ROT_0: begin
          x_o = cls_i.x;
          y_o = cls_i.y;
        end
        ROT_90: begin
          x_o = cls_i.y;
          y_o = x_mirror;
        end
        ROT_180: begin
          x_o = x_mirror;
          y_o = y_mirror;
        end
        ROT_270: begin
          x_o = y_mirror;
          y_o = cls_i.x;
        end
        default: begin
          x_o = cls_i.x;
          y_o = cls_i.y;
        end
      endcase
    end
  end

endmodule

// ----- tb/sv/tb.sv -----
module tb;
  import trd_pkg::*;

  localparam int unsigned LimitCycles = 200000;
  localparam int unsigned SegItems    = 88;
  localparam int unsigned HoldCycles  = 80;

  // contact codes that carry a position
  localparam logic [1:0] RAW_PRESS   = 2'd0;
  localparam logic [1:0] RAW_CONTACT = 2'd2;

  class touch_decode_tracker;
    rotation_e rotation;
    trd_out_t  pending[$];
    int        errors;

    function new();
      rotation = ROT_0;
      errors   = 0;
    endfunction

    function trd_out_t decode_report(trd_in_t r);
      trd_out_t    o;
      logic [1:0]  raw;
      logic [11:0] x, y, ox, oy;
      logic        ok, pos, prev_down;
      raw = r.x_high_byte[7:6];
      ok  = 1'b1;
      pos = 1'b0;
      x   = '0;
      y   = '0;
      if (r.finger_byte > 8'd1) begin
        ok = 1'b0;
      end else if (raw == RAW_LIFT || r.finger_byte == 8'd0) begin
        pos = 1'b0;
      end else if (raw == RAW_RESERVED) begin
        ok = 1'b0;
      end else begin
        x = {r.x_high_byte[3:0], r.x_low_byte};
        y = {r.y_high_byte[3:0], r.y_low_byte};
        if (x > PANEL_WIDTH || y > PANEL_HEIGHT) begin
          ok = 1'b0;
          x  = '0;
          y  = '0;
        end else begin
          if (x == PANEL_WIDTH) x = x - 12'd1;
          if (y == PANEL_HEIGHT) y = y - 12'd1;
          pos = 1'b1;
        end
      end
      o = '0;
      o.event_kind = EV_NONE;
      if (ok) begin
        prev_down = r.prior_seen && r.prior_pressed;
        if (pos) o.event_kind = prev_down ? EV_MOVE : EV_DOWN;
        else o.event_kind = prev_down ? EV_UP : EV_NONE;
        if (pos) begin
          ox = x;
          oy = y;
          case (rotation)
            ROT_90: begin
              x = oy;
              y = PANEL_WIDTH - 12'd1 - ox;
            end
            ROT_180: begin
              x = PANEL_WIDTH - 12'd1 - ox;
              y = PANEL_HEIGHT - 12'd1 - oy;
            end
            ROT_270: begin
              x = PANEL_HEIGHT - 12'd1 - oy;
              y = ox;
            end
            default: ;
          endcase
        end
      end
      o.accepted       = ok;
      o.x_position     = x;
      o.y_position     = y;
      o.pressed        = pos;
      o.position_valid = pos;
      o.gesture        = r.gesture_byte;
      o.finger_count   = r.finger_byte;
      o.event_code     = raw;
      return o;
    endfunction

    function void note_report(trd_in_t r);
      pending.push_back(decode_report(r));
    endfunction

    function void check_field(string name, logic [11:0] exp_v, logic [11:0] act_v);
      if (exp_v !== act_v) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_decode(trd_out_t act);
      trd_out_t exp_r;
      if (pending.size() == 0) begin
        $display("%0t: result beat with nothing pending, actual %0h", $time, act);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      check_field("accepted", 12'(exp_r.accepted), 12'(act.accepted));
      check_field("event_kind", 12'(exp_r.event_kind), 12'(act.event_kind));
      check_field("x_position", exp_r.x_position, act.x_position);
      check_field("y_position", exp_r.y_position, act.y_position);
      check_field("pressed", 12'(exp_r.pressed), 12'(act.pressed));
      check_field("position_valid", 12'(exp_r.position_valid),
                  12'(act.position_valid));
      check_field("gesture", 12'(exp_r.gesture), 12'(act.gesture));
      check_field("finger_count", 12'(exp_r.finger_count), 12'(act.finger_count));
      check_field("event_code", 12'(exp_r.event_code), 12'(act.event_code));
    endfunction
  endclass

  logic       clk_i;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready_o;
  trd_in_t    in_data;
  logic       out_valid_o;
  logic       out_ready;
  trd_out_t   out_data_o;
  logic       cfg_valid;
  logic       cfg_ready_o;
  logic [1:0] cfg_data;

  touch_decode_tracker tracker;
  int  src_idle_pct;
  int  sink_idle_pct;
  bit  hold_req;
  int  hold_left;
  int  cycle_count;

  touch_report_decoder u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  always @(posedge clk_i) begin
    cycle_count = cycle_count + 1;
    if (cycle_count > LimitCycles) begin
      $display("%0t: timeout", $time);
      $display("status: fail");
      $finish;
    end
  end

  // result side: sample at the rising edge
  always @(posedge clk_i) begin
    if (rst_n && out_valid_o && out_ready) tracker.check_decode(out_data_o);
  end

  // receiver back-pressure, with an occasional long hold-off
  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end
  end

  function automatic trd_in_t make_report(logic [7:0] gest, logic [7:0] fing,
                                          logic [1:0] raw, logic [11:0] x,
                                          logic [11:0] y, logic pv, logic pp);
    trd_in_t    r;
    logic [7:0] fill;
    fill             = 8'($urandom);
    r.gesture_byte   = gest;
    r.finger_byte    = fing;
    r.x_high_byte    = {raw, fill[1:0], x[11:8]};
    r.x_low_byte     = x[7:0];
    r.y_high_byte    = {fill[7:4], y[11:8]};
    r.y_low_byte     = y[7:0];
    r.prior_seen     = pv;
    r.prior_pressed  = pp;
    return r;
  endfunction

  function automatic logic [11:0] pick_coord(logic [11:0] size);
    case ($urandom_range(0, 9))
      0: return 12'd0;
      1: return size;
      2: return size - 12'd1;
      default: return 12'($urandom_range(0, size));
    endcase
  endfunction

  function automatic trd_in_t random_report();
    int         kind;
    int         rsel;
    logic [1:0] raw;
    logic [7:0] fing;
    kind = $urandom_range(0, 99);
    if (kind < 70) begin
      rsel = $urandom_range(0, 9);
      if (rsel < 4) raw = RAW_PRESS;
      else if (rsel < 8) raw = RAW_CONTACT;
      else if (rsel == 8) raw = RAW_LIFT;
      else raw = RAW_RESERVED;
      fing = ($urandom_range(0, 9) == 0) ? 8'd0 : 8'd1;
      return make_report(8'($urandom), fing, raw, pick_coord(PANEL_WIDTH),
                         pick_coord(PANEL_HEIGHT), 1'($urandom), 1'($urandom));
    end else if (kind < 85) begin
      // coordinates anywhere in the 12-bit range, mostly off the panel
      return make_report(8'($urandom), 8'd1, 2'($urandom), 12'($urandom),
                         12'($urandom), 1'($urandom), 1'($urandom));
    end
    return make_report(8'($urandom), 8'($urandom), 2'($urandom), 12'($urandom),
                       12'($urandom), 1'($urandom), 1'($urandom));
  endfunction

  // called at a falling edge, returns at a falling edge after the beat
  task automatic send_report(trd_in_t r);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    tracker.note_report(r);
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (tracker.pending.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_rotation(rotation_e rot);
    cfg_valid <= 1'b1;
    cfg_data  <= rot;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    tracker.rotation = rot;
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  rotation_e rot_plan[8] = '{ROT_90, ROT_270, ROT_0, ROT_180,
                             ROT_180, ROT_0, ROT_270, ROT_90};

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data       = '0;
    out_ready     = 1'b0;
    cfg_valid     = 1'b0;
    cfg_data      = ROT_0;
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    hold_req      = 1'b0;
    hold_left     = 0;
    cycle_count   = 0;
    tracker       = new();
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_n = 1'b1;
    @(negedge clk_i);

    // directed reports, rotation still at its reset value
    send_report(make_report(8'h00, 8'd1, RAW_PRESS, 12'd0, 12'd0, 1'b0, 1'b0));
    send_report(make_report(8'hff, 8'd1, RAW_CONTACT, 12'd240, 12'd280, 1'b1, 1'b1));
    send_report(make_report(8'h5a, 8'd1, RAW_PRESS, 12'd239, 12'd279, 1'b1, 1'b0));
    send_report(make_report(8'h01, 8'd1, RAW_CONTACT, 12'd241, 12'd0, 1'b0, 1'b1));
    send_report(make_report(8'h80, 8'd1, RAW_PRESS, 12'd0, 12'd281, 1'b1, 1'b1));
    send_report(make_report(8'hff, 8'd1, RAW_CONTACT, 12'hfff, 12'hfff, 1'b1, 1'b1));
    send_report(make_report(8'h10, 8'd0, RAW_PRESS, 12'd100, 12'd100, 1'b1, 1'b1));
    send_report(make_report(8'h11, 8'd0, RAW_CONTACT, 12'd5, 12'd5, 1'b0, 1'b1));
    send_report(make_report(8'h12, 8'd1, RAW_LIFT, 12'd50, 12'd60, 1'b1, 1'b1));
    send_report(make_report(8'h13, 8'd0, RAW_LIFT, 12'hfff, 12'hfff, 1'b0, 1'b0));
    send_report(make_report(8'h14, 8'd1, RAW_RESERVED, 12'd10, 12'd10, 1'b1, 1'b1));
    send_report(make_report(8'h15, 8'd0, RAW_RESERVED, 12'd10, 12'd10, 1'b1, 1'b1));
    send_report(make_report(8'h16, 8'd2, RAW_PRESS, 12'd10, 12'd10, 1'b1, 1'b1));
    send_report(make_report(8'h17, 8'hff, RAW_LIFT, 12'd10, 12'd10, 1'b1, 1'b1));
    send_report(make_report(8'h18, 8'hfe, RAW_RESERVED, 12'hfff, 12'd0, 1'b0, 1'b0));
    send_report(make_report(8'h19, 8'd1, RAW_CONTACT, 12'd120, 12'd140, 1'b1, 1'b0));
    send_report(make_report(8'h1a, 8'd1, RAW_CONTACT, 12'd120, 12'd140, 1'b0, 1'b1));
    send_report(make_report(8'h1b, 8'd1, RAW_PRESS, 12'd240, 12'd0, 1'b1, 1'b1));
    send_report(make_report(8'h1c, 8'd1, RAW_PRESS, 12'd0, 12'd280, 1'b0, 1'b0));
    send_report(make_report(8'h1d, 8'd1, RAW_CONTACT, 12'h0f0, 12'h118, 1'b1, 1'b1));
    drain_results();

    for (int seg = 0; seg < 8; seg++) begin
      if (seg < 3) begin
        src_idle_pct  = 23;
        sink_idle_pct = 76;
      end else if (seg < 6) begin
        src_idle_pct  = 76;
        sink_idle_pct = 23;
      end else begin
        src_idle_pct  = 0;
        sink_idle_pct = 0;
      end
      write_rotation(rot_plan[seg]);
      // long receiver stall while reports keep coming
      if (seg == 1 || seg == 6) hold_req = 1'b1;
      repeat (SegItems) send_report(random_report());
      drain_results();
    end

    if (tracker.errors == 0 && tracker.pending.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
